// ----- rtl/core/gbn_pkg.sv -----
// Shared types, constants and control/status bundles of the Go-Back-N window engine.
// No dependencies; used by gbn_ctrl, gbn_dp and go_back_n_window_engine.
package gbn_pkg;

  localparam int unsigned WINDOW_SIZE_DEF = 8;
  localparam int unsigned MAX_PAYLOAD     = 1024;

  localparam int unsigned SEQ_W      = 32;
  localparam int unsigned REF_W      = 16;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned TMO_W      = 32;
  localparam int unsigned SHIFT_W    = 3;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned ACT_W      = 3;
  localparam int unsigned TCMD_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned ENTRY_W    = REF_W + LEN_W;

  localparam logic [TMO_W-1:0]   RTT_EST_RST  = 32'd800000;
  localparam logic [TMO_W-1:0]   RTT_DEV_RST  = 32'd80000;
  localparam logic [TMO_W-1:0]   INIT_TMO_RST = 32'd1000000;
  localparam logic [SHIFT_W-1:0] ALPHA_RST    = 3'd3;
  localparam logic [SHIFT_W-1:0] BETA_RST     = 3'd2;
  localparam logic [SEQ_W-1:0]   SEQ_RST      = 32'd1;
  localparam logic [SEQ_W-1:0]   ACK_RST      = 32'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA    = 2'd0,
    CFG_BETA     = 2'd1,
    CFG_ADAPT    = 2'd2,
    CFG_INIT_TMO = 2'd3
  } cfg_idx_e;

  typedef enum logic [OP_W-1:0] {
    OP_SEND    = 2'd0,
    OP_ACK     = 2'd1,
    OP_DATA    = 2'd2,
    OP_TIMEOUT = 2'd3
  } op_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE    = 3'd0,
    ACT_TX      = 3'd1,
    ACT_ACK     = 3'd2,
    ACT_DELIVER = 3'd3,
    ACT_FULL    = 3'd4,
    ACT_IGNORED = 3'd5
  } action_e;

  typedef enum logic [TCMD_W-1:0] {
    TMR_LEAVE = 2'd0,
    TMR_START = 2'd1,
    TMR_STOP  = 2'd2
  } timer_e;

  // Result kinds that the datapath can build into the output register.
  typedef enum logic [3:0] {
    RES_REJ_NEXT,
    RES_FULL,
    RES_TX_NEW,
    RES_ACK_OK,
    RES_IGN_SEQ,
    RES_DELIVER,
    RES_ACK_SEND,
    RES_TACK,
    RES_TX_OLD
  } res_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RTT_EST,
    ST_RTT_DEV,
    ST_RTT_TMO,
    ST_DELIVER,
    ST_FINAL,
    ST_TACK,
    ST_WALK_RD,
    ST_WALK_TX
  } state_e;

  typedef struct packed {
    logic latch;
    logic load_out;
    res_e res;
    logic do_send;
    logic do_ack;
    logic do_deliver;
    logic rtt_est;
    logic rtt_dev;
    logic rtt_tmo;
    logic walk_init;
    logic walk_step;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic len_bad;
    logic win_full;
    logic ack_ok;
    logic data_bad;
    logic in_order;
    logic adapt;
    logic out_free;
    logic count_zero;
    logic walk_last;
  } sts_t;

endpackage

// ----- rtl/core/go_back_n_window_engine.sv -----
// Top level of the Go-Back-N window engine: sequencer plus datapath.
// Depends on gbn_pkg, gbn_ctrl and gbn_dp.
//
//   channel   direction  handshake                   payload
//   event     in         in_valid_i / in_ready_o     op, seq_num, checksum_ok, payload
//   result    out        out_valid_o / out_ready_i   action, out_seq, out_ref/len, timer
//   config    in         cfg_we_i (no wait)          cfg_idx_i, cfg_data_i
//
// One event at a time: in_ready_o is high only while the sequencer is idle.
// Steps from accept: decode, then final for a send, a rejected event or a plain ack;
// an ack with RTT adaptation adds three estimator steps, in-order data a deliver
// step, a timeout the ack result, then a store read and a transfer per outstanding
// packet. A held result in the output register stalls the sequencer only when it has
// the next result ready. Reset clears all control and connection state at once.
module go_back_n_window_engine #(
  parameter int unsigned WINDOW_SIZE = gbn_pkg::WINDOW_SIZE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [gbn_pkg::OP_W-1:0]       op_i,
  input  logic [gbn_pkg::SEQ_W-1:0]      seq_num_i,
  input  logic                           checksum_ok_i,
  input  logic [gbn_pkg::REF_W-1:0]      payload_ref_i,
  input  logic [gbn_pkg::LEN_W-1:0]      payload_len_i,
  input  logic [gbn_pkg::TMO_W-1:0]      rtt_sample_ns_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [gbn_pkg::ACT_W-1:0]      action_o,
  output logic [gbn_pkg::SEQ_W-1:0]      out_seq_o,
  output logic [gbn_pkg::REF_W-1:0]      out_ref_o,
  output logic [gbn_pkg::LEN_W-1:0]      out_len_o,
  output logic [gbn_pkg::TCMD_W-1:0]     timer_cmd_o,
  output logic [gbn_pkg::TMO_W-1:0]      timeout_ns_o,
  output logic                           last_o,
  input  logic                           cfg_we_i,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  gbn_pkg::cmd_t cmd;
  gbn_pkg::sts_t sts;

  gbn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gbn_dp #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op_i),
    .seq_num_i       (seq_num_i),
    .checksum_ok_i   (checksum_ok_i),
    .payload_ref_i   (payload_ref_i),
    .payload_len_i   (payload_len_i),
    .rtt_sample_ns_i (rtt_sample_ns_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .action_o        (action_o),
    .out_seq_o       (out_seq_o),
    .out_ref_o       (out_ref_o),
    .out_len_o       (out_len_o),
    .timer_cmd_o     (timer_cmd_o),
    .timeout_ns_o    (timeout_ns_o),
    .last_o          (last_o)
  );

endmodule

// ----- rtl/core/gbn_ctrl.sv -----
// Sequencer of the Go-Back-N window engine: decodes each event and steps the datapath.
// Depends on gbn_pkg for the state, result and command/status types.
module gbn_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gbn_pkg::sts_t sts_i,
  output gbn_pkg::cmd_t cmd_o
);

  gbn_pkg::state_e state_q, state_d;
  gbn_pkg::res_e   res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gbn_pkg::ST_IDLE;
      res_q   <= gbn_pkg::RES_REJ_NEXT;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    res_d      = res_q;
    cmd_o      = '0;
    cmd_o.res  = res_q;
    in_ready_o = 1'b0;
    case (state_q)
      gbn_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.latch  = in_valid_i;
        if (in_valid_i) begin
          state_d = gbn_pkg::ST_DECODE;
        end
      end
      gbn_pkg::ST_DECODE: begin
        state_d = gbn_pkg::ST_FINAL;
        case (sts_i.op)
          gbn_pkg::OP_SEND: begin
            if (sts_i.len_bad) begin
              res_d = gbn_pkg::RES_REJ_NEXT;
            end else if (sts_i.win_full) begin
              res_d = gbn_pkg::RES_FULL;
            end else begin
              res_d = gbn_pkg::RES_TX_NEW;
            end
          end
          gbn_pkg::OP_ACK: begin
            if (sts_i.ack_ok) begin
              cmd_o.do_ack = 1'b1;
              res_d        = gbn_pkg::RES_ACK_OK;
              if (sts_i.adapt) begin
                state_d = gbn_pkg::ST_RTT_EST;
              end
            end else begin
              res_d = gbn_pkg::RES_IGN_SEQ;
            end
          end
          gbn_pkg::OP_DATA: begin
            if (sts_i.data_bad) begin
              res_d = gbn_pkg::RES_IGN_SEQ;
            end else if (sts_i.in_order) begin
              state_d = gbn_pkg::ST_DELIVER;
            end else begin
              res_d = gbn_pkg::RES_ACK_SEND;
            end
          end
          default: begin
            cmd_o.walk_init = 1'b1;
            state_d         = gbn_pkg::ST_TACK;
          end
        endcase
      end
      gbn_pkg::ST_RTT_EST: begin
        cmd_o.rtt_est = 1'b1;
        state_d       = gbn_pkg::ST_RTT_DEV;
      end
      gbn_pkg::ST_RTT_DEV: begin
        cmd_o.rtt_dev = 1'b1;
        state_d       = gbn_pkg::ST_RTT_TMO;
      end
      gbn_pkg::ST_RTT_TMO: begin
        cmd_o.rtt_tmo = 1'b1;
        state_d       = gbn_pkg::ST_FINAL;
      end
      gbn_pkg::ST_DELIVER: begin
        cmd_o.res = gbn_pkg::RES_DELIVER;
        if (sts_i.out_free) begin
          cmd_o.load_out   = 1'b1;
          cmd_o.do_deliver = 1'b1;
          res_d            = gbn_pkg::RES_ACK_SEND;
          state_d          = gbn_pkg::ST_FINAL;
        end
      end
      gbn_pkg::ST_FINAL: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.do_send  = (res_q == gbn_pkg::RES_TX_NEW);
          state_d        = gbn_pkg::ST_IDLE;
        end
      end
      gbn_pkg::ST_TACK: begin
        cmd_o.res = gbn_pkg::RES_TACK;
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = sts_i.count_zero ? gbn_pkg::ST_IDLE : gbn_pkg::ST_WALK_RD;
        end
      end
      gbn_pkg::ST_WALK_RD: begin
        // wait state for the registered store read of the current window slot
        state_d = gbn_pkg::ST_WALK_TX;
      end
      gbn_pkg::ST_WALK_TX: begin
        cmd_o.res = gbn_pkg::RES_TX_OLD;
        if (sts_i.out_free) begin
          cmd_o.load_out  = 1'b1;
          cmd_o.walk_step = 1'b1;
          state_d = sts_i.walk_last ? gbn_pkg::ST_IDLE : gbn_pkg::ST_WALK_RD;
        end
      end
      default: begin
        state_d = gbn_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/gbn_dp.sv -----
// Datapath of the Go-Back-N window engine: event latch, connection state, window
// store, RTT estimator, retransmit walk and output register. Depends on gbn_pkg.
module gbn_dp #(
  parameter int unsigned WINDOW_SIZE = gbn_pkg::WINDOW_SIZE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [gbn_pkg::OP_W-1:0]       op_i,
  input  logic [gbn_pkg::SEQ_W-1:0]      seq_num_i,
  input  logic                           checksum_ok_i,
  input  logic [gbn_pkg::REF_W-1:0]      payload_ref_i,
  input  logic [gbn_pkg::LEN_W-1:0]      payload_len_i,
  input  logic [gbn_pkg::TMO_W-1:0]      rtt_sample_ns_i,
  input  logic                           cfg_we_i,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  gbn_pkg::cmd_t                  cmd_i,
  output gbn_pkg::sts_t                  sts_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [gbn_pkg::ACT_W-1:0]      action_o,
  output logic [gbn_pkg::SEQ_W-1:0]      out_seq_o,
  output logic [gbn_pkg::REF_W-1:0]      out_ref_o,
  output logic [gbn_pkg::LEN_W-1:0]      out_len_o,
  output logic [gbn_pkg::TCMD_W-1:0]     timer_cmd_o,
  output logic [gbn_pkg::TMO_W-1:0]      timeout_ns_o,
  output logic                           last_o
);

  localparam int unsigned IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int unsigned CNT_W = $clog2(WINDOW_SIZE + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam logic [IDX_W-1:0] IDX_RST  = IDX_W'(1 % WINDOW_SIZE);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_SIZE - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_SIZE);
  localparam logic [SUM_W-1:0] SUM_WRAP = SUM_W'(WINDOW_SIZE);
  localparam logic [gbn_pkg::SEQ_W-1:0] WIN_SEQ = gbn_pkg::SEQ_W'(WINDOW_SIZE);

  // latched event
  logic [gbn_pkg::OP_W-1:0]  op_q;
  logic [gbn_pkg::SEQ_W-1:0] seq_q;
  logic                      ck_q;
  logic [gbn_pkg::REF_W-1:0] ref_q;
  logic [gbn_pkg::LEN_W-1:0] len_q;
  logic [gbn_pkg::TMO_W-1:0] smp_q;
  logic [gbn_pkg::TMO_W-1:0] tmo_q;
  logic [gbn_pkg::TMO_W-1:0] tmo_snap;

  // configuration and connection state
  logic [gbn_pkg::SHIFT_W-1:0] alpha_q, beta_q;
  logic                        adapt_q;
  logic [gbn_pkg::SEQ_W-1:0]   base_q, next_q, exp_q, lack_q;
  logic                        busy_q;
  logic [IDX_W-1:0]            base_idx_q, next_idx_q;
  logic [gbn_pkg::TMO_W-1:0]   est_q, dev_q, cur_tmo_q;

  // window store and retransmit walk
  logic [gbn_pkg::ENTRY_W-1:0] store_q [WINDOW_SIZE];
  logic [gbn_pkg::ENTRY_W-1:0] rd_data_q;
  logic [IDX_W-1:0]            rd_idx_q;
  logic [CNT_W-1:0]            walk_i_q, cnt_q;

  logic                      cfg_tmo_wr;
  logic [gbn_pkg::SEQ_W-1:0] seq_inc, out_span, ack_off, ack_span;
  logic [CNT_W-1:0]          count;
  logic [SUM_W-1:0]          base_sum;
  logic [IDX_W-1:0]          base_idx_new, next_idx_inc, rd_idx_inc;
  logic                      walk_last;

  logic [gbn_pkg::TMO_W:0]   est_sum, dev_sum;
  logic [gbn_pkg::TMO_W+2:0] tmo_sum;
  logic [gbn_pkg::TMO_W-1:0] rtt_diff;

  gbn_pkg::action_e          res_act;
  logic [gbn_pkg::SEQ_W-1:0] res_seq;
  logic [gbn_pkg::REF_W-1:0] res_ref;
  logic [gbn_pkg::LEN_W-1:0] res_len;
  gbn_pkg::timer_e           res_tcmd;
  logic                      res_last;
  logic                      out_valid_q;

  assign cfg_tmo_wr = cfg_we_i &&
                      (gbn_pkg::cfg_idx_e'(cfg_idx_i) == gbn_pkg::CFG_INIT_TMO);
  // a timeout write in the accept cycle is already in force for that event
  assign tmo_snap = cfg_tmo_wr ? cfg_data_i : cur_tmo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= op_i;
      seq_q <= seq_num_i;
      ck_q  <= checksum_ok_i;
      ref_q <= payload_ref_i;
      len_q <= payload_len_i;
      smp_q <= rtt_sample_ns_i;
      tmo_q <= tmo_snap;
    end
  end

  // window arithmetic
  assign seq_inc  = seq_q + 1'b1;
  assign out_span = next_q - base_q;
  assign ack_off  = seq_q - base_q;
  assign ack_span = seq_inc - base_q;
  assign count    = (out_span > WIN_SEQ) ? CNT_FULL : out_span[CNT_W-1:0];
  // new base slot: old slot plus the acked span, which never exceeds the window
  assign base_sum = SUM_W'(base_idx_q) + SUM_W'(ack_span[CNT_W-1:0]);
  assign base_idx_new = (base_sum >= SUM_WRAP) ? IDX_W'(base_sum - SUM_WRAP)
                                               : IDX_W'(base_sum);
  assign next_idx_inc = (next_idx_q == IDX_LAST) ? '0 : next_idx_q + 1'b1;
  assign rd_idx_inc   = (rd_idx_q == IDX_LAST) ? '0 : rd_idx_q + 1'b1;
  assign walk_last    = (CNT_W'(walk_i_q + 1'b1) == cnt_q);

  // RTT estimator, one step per cycle
  assign est_sum = {1'b0, est_q} - {1'b0, est_q >> alpha_q} + {1'b0, smp_q >> alpha_q};
  assign rtt_diff = (smp_q > est_q) ? smp_q - est_q : est_q - smp_q;
  assign dev_sum = {1'b0, dev_q} - {1'b0, dev_q >> beta_q} + {1'b0, rtt_diff >> beta_q};
  assign tmo_sum = {3'b000, est_q} + {1'b0, dev_q, 2'b00};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q    <= gbn_pkg::ALPHA_RST;
      beta_q     <= gbn_pkg::BETA_RST;
      adapt_q    <= 1'b1;
      base_q     <= gbn_pkg::SEQ_RST;
      next_q     <= gbn_pkg::SEQ_RST;
      exp_q      <= gbn_pkg::SEQ_RST;
      lack_q     <= gbn_pkg::ACK_RST;
      busy_q     <= 1'b0;
      base_idx_q <= IDX_RST;
      next_idx_q <= IDX_RST;
      est_q      <= gbn_pkg::RTT_EST_RST;
      dev_q      <= gbn_pkg::RTT_DEV_RST;
      cur_tmo_q  <= gbn_pkg::INIT_TMO_RST;
      rd_idx_q   <= '0;
      walk_i_q   <= '0;
      cnt_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (gbn_pkg::cfg_idx_e'(cfg_idx_i))
          gbn_pkg::CFG_ALPHA:    alpha_q   <= cfg_data_i[gbn_pkg::SHIFT_W-1:0];
          gbn_pkg::CFG_BETA:     beta_q    <= cfg_data_i[gbn_pkg::SHIFT_W-1:0];
          gbn_pkg::CFG_ADAPT:    adapt_q   <= cfg_data_i[0];
          gbn_pkg::CFG_INIT_TMO: cur_tmo_q <= cfg_data_i[gbn_pkg::TMO_W-1:0];
          default: ;
        endcase
      end else if (cmd_i.rtt_tmo) begin
        cur_tmo_q <= (|tmo_sum[gbn_pkg::TMO_W+2:gbn_pkg::TMO_W]) ? '1
                                                               : tmo_sum[gbn_pkg::TMO_W-1:0];
      end
      if (cmd_i.rtt_est) begin
        est_q <= est_sum[gbn_pkg::TMO_W] ? '1 : est_sum[gbn_pkg::TMO_W-1:0];
      end
      if (cmd_i.rtt_dev) begin
        dev_q <= dev_sum[gbn_pkg::TMO_W] ? '1 : dev_sum[gbn_pkg::TMO_W-1:0];
      end
      if (cmd_i.do_send) begin
        next_q     <= next_q + 1'b1;
        next_idx_q <= next_idx_inc;
        busy_q     <= 1'b1;
      end
      if (cmd_i.do_ack) begin
        base_q     <= seq_inc;
        base_idx_q <= base_idx_new;
        if (seq_inc == next_q) begin
          busy_q <= 1'b0;
        end
      end
      if (cmd_i.do_deliver) begin
        lack_q <= seq_q;
        exp_q  <= exp_q + 1'b1;
      end
      if (cmd_i.walk_init) begin
        cnt_q    <= count;
        walk_i_q <= '0;
        rd_idx_q <= base_idx_q;
      end else if (cmd_i.walk_step) begin
        walk_i_q <= walk_i_q + 1'b1;
        rd_idx_q <= rd_idx_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_send) begin
      store_q[next_idx_q] <= {ref_q, len_q};
    end
    rd_data_q <= store_q[rd_idx_q];
  end

  // status for the sequencer
  always_comb begin
    sts_o            = '0;
    sts_o.op         = gbn_pkg::op_e'(op_q);
    sts_o.len_bad    = 32'(len_q) > 32'(gbn_pkg::MAX_PAYLOAD);
    sts_o.win_full   = out_span >= WIN_SEQ;
    sts_o.ack_ok     = ack_off < out_span;
    sts_o.data_bad   = !ck_q || sts_o.len_bad;
    sts_o.in_order   = (seq_q == exp_q) && !busy_q;
    sts_o.adapt      = adapt_q;
    sts_o.out_free   = !out_valid_q || out_ready_i;
    sts_o.count_zero = (cnt_q == '0);
    sts_o.walk_last  = walk_last;
  end

  // result builder
  always_comb begin
    res_act  = gbn_pkg::ACT_NONE;
    res_seq  = seq_q;
    res_ref  = '0;
    res_len  = '0;
    res_tcmd = gbn_pkg::TMR_LEAVE;
    res_last = 1'b1;
    case (cmd_i.res)
      gbn_pkg::RES_REJ_NEXT: begin
        res_act = gbn_pkg::ACT_IGNORED;
        res_seq = next_q;
      end
      gbn_pkg::RES_FULL: begin
        res_act = gbn_pkg::ACT_FULL;
        res_seq = next_q;
      end
      gbn_pkg::RES_TX_NEW: begin
        res_act  = gbn_pkg::ACT_TX;
        res_seq  = next_q;
        res_ref  = ref_q;
        res_len  = len_q;
        res_tcmd = (base_q == next_q) ? gbn_pkg::TMR_START : gbn_pkg::TMR_LEAVE;
      end
      gbn_pkg::RES_ACK_OK: begin
        res_tcmd = (seq_inc == next_q) ? gbn_pkg::TMR_STOP : gbn_pkg::TMR_START;
      end
      gbn_pkg::RES_IGN_SEQ: begin
        res_act = gbn_pkg::ACT_IGNORED;
      end
      gbn_pkg::RES_DELIVER: begin
        res_act  = gbn_pkg::ACT_DELIVER;
        res_ref  = ref_q;
        res_len  = len_q;
        res_tcmd = (exp_q == gbn_pkg::SEQ_RST) ? gbn_pkg::TMR_STOP : gbn_pkg::TMR_LEAVE;
        res_last = 1'b0;
      end
      gbn_pkg::RES_ACK_SEND: begin
        res_act = gbn_pkg::ACT_ACK;
        res_seq = lack_q;
      end
      gbn_pkg::RES_TACK: begin
        res_act  = gbn_pkg::ACT_ACK;
        res_seq  = lack_q;
        res_tcmd = (cnt_q == '0) ? gbn_pkg::TMR_START : gbn_pkg::TMR_LEAVE;
        res_last = (cnt_q == '0);
      end
      gbn_pkg::RES_TX_OLD: begin
        res_act  = gbn_pkg::ACT_TX;
        res_seq  = base_q + gbn_pkg::SEQ_W'(walk_i_q);
        res_ref  = rd_data_q[gbn_pkg::ENTRY_W-1:gbn_pkg::LEN_W];
        res_len  = rd_data_q[gbn_pkg::LEN_W-1:0];
        res_tcmd = walk_last ? gbn_pkg::TMR_START : gbn_pkg::TMR_LEAVE;
        res_last = walk_last;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      action_o     <= res_act;
      out_seq_o    <= res_seq;
      out_ref_o    <= res_ref;
      out_len_o    <= res_len;
      timer_cmd_o  <= res_tcmd;
      timeout_ns_o <= tmo_q;
      last_o       <= res_last;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_span <= WIN_SEQ)
    else $error("outstanding packets exceed the window");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_q |-> base_q == next_q)
    else $error("sender idle with packets outstanding");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.walk_step |-> walk_i_q < cnt_q)
    else $error("retransmit walk past the outstanding count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten before transfer");
`endif

endmodule

// ----- tb/go_back_n_window_engine_tb.sv -----
// Self-checking testbench of the Go-Back-N window engine: directed events, then random
// event streams under several register settings and flow-control patterns.
// Depends on gbn_pkg and go_back_n_window_engine.
module go_back_n_window_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    gbn_pkg::op_e                 op;
    logic [gbn_pkg::SEQ_W-1:0]    seq;
    logic                         ck;
    logic [gbn_pkg::REF_W-1:0]    pref;
    logic [gbn_pkg::LEN_W-1:0]    plen;
    logic [gbn_pkg::TMO_W-1:0]    sample;
  } gbn_event_t;

  typedef struct packed {
    gbn_pkg::action_e             act;
    logic [gbn_pkg::SEQ_W-1:0]    seq;
    logic [gbn_pkg::REF_W-1:0]    pref;
    logic [gbn_pkg::LEN_W-1:0]    plen;
    gbn_pkg::timer_e              tcmd;
    logic [gbn_pkg::TMO_W-1:0]    tmo;
    logic                         fin;
  } gbn_result_t;

  // Connection state mirror; turns each accepted event into the results it must produce.
  class gbn_expect_book;
    logic [gbn_pkg::SHIFT_W-1:0] alpha_sh;
    logic [gbn_pkg::SHIFT_W-1:0] beta_sh;
    logic                        adapt_en;
    logic [gbn_pkg::SEQ_W-1:0]   base;
    logic [gbn_pkg::SEQ_W-1:0]   next_sq;
    logic [gbn_pkg::SEQ_W-1:0]   exp_sq;
    logic [gbn_pkg::SEQ_W-1:0]   last_ack;
    logic                        busy;
    logic [gbn_pkg::ENTRY_W-1:0] slots [gbn_pkg::WINDOW_SIZE_DEF];
    logic [gbn_pkg::TMO_W-1:0]   est;
    logic [gbn_pkg::TMO_W-1:0]   dev;
    logic [gbn_pkg::TMO_W-1:0]   cur_tmo;
    gbn_result_t                 awaited[$];
    int unsigned                 errors;

    function new();
      alpha_sh = gbn_pkg::ALPHA_RST;
      beta_sh  = gbn_pkg::BETA_RST;
      adapt_en = 1'b1;
      base     = gbn_pkg::SEQ_RST;
      next_sq  = gbn_pkg::SEQ_RST;
      exp_sq   = gbn_pkg::SEQ_RST;
      last_ack = gbn_pkg::ACK_RST;
      busy     = 1'b0;
      est      = gbn_pkg::RTT_EST_RST;
      dev      = gbn_pkg::RTT_DEV_RST;
      cur_tmo  = gbn_pkg::INIT_TMO_RST;
      errors   = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function void set_reg(gbn_pkg::cfg_idx_e idx, logic [gbn_pkg::CFG_DATA_W-1:0] d);
      case (idx)
        gbn_pkg::CFG_ALPHA:    alpha_sh = d[gbn_pkg::SHIFT_W-1:0];
        gbn_pkg::CFG_BETA:     beta_sh  = d[gbn_pkg::SHIFT_W-1:0];
        gbn_pkg::CFG_ADAPT:    adapt_en = d[0];
        gbn_pkg::CFG_INIT_TMO: cur_tmo  = d;
        default: ;
      endcase
    endfunction

    function logic [gbn_pkg::TMO_W-1:0] sat32(logic [63:0] v);
      return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function void push_result(gbn_pkg::action_e a, logic [gbn_pkg::SEQ_W-1:0] s,
                              logic [gbn_pkg::REF_W-1:0] r, logic [gbn_pkg::LEN_W-1:0] l,
                              gbn_pkg::timer_e t, logic f);
      gbn_result_t res;
      res = '{act: a, seq: s, pref: r, plen: l, tcmd: t, tmo: cur_tmo, fin: f};
      awaited.push_back(res);
    endfunction

    // Weighted estimate first, deviation against the new estimate, then the timeout.
    function void refine_rtt(logic [gbn_pkg::TMO_W-1:0] sample);
      logic [63:0] e_w;
      logic [63:0] d_w;
      logic [63:0] s_w;
      logic [63:0] diff;
      e_w  = {32'b0, est};
      d_w  = {32'b0, dev};
      s_w  = {32'b0, sample};
      e_w  = e_w - (e_w >> alpha_sh) + (s_w >> alpha_sh);
      est  = sat32(e_w);
      e_w  = {32'b0, est};
      diff = (s_w > e_w) ? s_w - e_w : e_w - s_w;
      d_w  = d_w - (d_w >> beta_sh) + (diff >> beta_sh);
      dev  = sat32(d_w);
      cur_tmo = sat32({32'b0, est} + ({32'b0, dev} << 2));
    endfunction

    function void note_event(gbn_event_t ev);
      logic [gbn_pkg::SEQ_W-1:0]   cnt;
      logic [gbn_pkg::SEQ_W-1:0]   s;
      logic [gbn_pkg::ENTRY_W-1:0] e;
      gbn_pkg::timer_e             t;
      logic                        f;
      case (ev.op)
        gbn_pkg::OP_SEND: begin
          if (ev.plen > gbn_pkg::MAX_PAYLOAD) begin
            push_result(gbn_pkg::ACT_IGNORED, next_sq, '0, '0, gbn_pkg::TMR_LEAVE, 1'b1);
          end else if (next_sq - base >= gbn_pkg::WINDOW_SIZE_DEF) begin
            push_result(gbn_pkg::ACT_FULL, next_sq, '0, '0, gbn_pkg::TMR_LEAVE, 1'b1);
          end else begin
            slots[next_sq % gbn_pkg::WINDOW_SIZE_DEF] = {ev.pref, ev.plen};
            t = (base == next_sq) ? gbn_pkg::TMR_START : gbn_pkg::TMR_LEAVE;
            push_result(gbn_pkg::ACT_TX, next_sq, ev.pref, ev.plen, t, 1'b1);
            next_sq = next_sq + 1;
            busy    = 1'b1;
          end
        end
        gbn_pkg::OP_ACK: begin
          if (ev.seq - base >= next_sq - base) begin
            push_result(gbn_pkg::ACT_IGNORED, ev.seq, '0, '0, gbn_pkg::TMR_LEAVE, 1'b1);
          end else begin
            base = ev.seq + 1;
            if (base == next_sq) begin
              t    = gbn_pkg::TMR_STOP;
              busy = 1'b0;
            end else begin
              t = gbn_pkg::TMR_START;
            end
            // the result carries the timeout from before the estimator runs
            push_result(gbn_pkg::ACT_NONE, ev.seq, '0, '0, t, 1'b1);
            if (adapt_en) refine_rtt(ev.sample);
          end
        end
        gbn_pkg::OP_DATA: begin
          if (!ev.ck || ev.plen > gbn_pkg::MAX_PAYLOAD) begin
            push_result(gbn_pkg::ACT_IGNORED, ev.seq, '0, '0, gbn_pkg::TMR_LEAVE, 1'b1);
          end else begin
            if (ev.seq == exp_sq && !busy) begin
              t = (exp_sq == 1) ? gbn_pkg::TMR_STOP : gbn_pkg::TMR_LEAVE;
              push_result(gbn_pkg::ACT_DELIVER, ev.seq, ev.pref, ev.plen, t, 1'b0);
              last_ack = ev.seq;
              exp_sq   = exp_sq + 1;
            end
            push_result(gbn_pkg::ACT_ACK, last_ack, '0, '0, gbn_pkg::TMR_LEAVE, 1'b1);
          end
        end
        default: begin
          cnt = next_sq - base;
          if (cnt > gbn_pkg::WINDOW_SIZE_DEF) cnt = gbn_pkg::WINDOW_SIZE_DEF;
          t = (cnt == 0) ? gbn_pkg::TMR_START : gbn_pkg::TMR_LEAVE;
          push_result(gbn_pkg::ACT_ACK, last_ack, '0, '0, t, cnt == 0);
          for (int unsigned i = 0; i < cnt; i++) begin
            s = base + i;
            e = slots[s % gbn_pkg::WINDOW_SIZE_DEF];
            f = (i + 1 == cnt);
            push_result(gbn_pkg::ACT_TX, s, e[gbn_pkg::ENTRY_W-1:gbn_pkg::LEN_W],
                        e[gbn_pkg::LEN_W-1:0],
                        f ? gbn_pkg::TMR_START : gbn_pkg::TMR_LEAVE, f);
          end
        end
      endcase
    endfunction

    function void check_result(gbn_result_t got);
      gbn_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result with nothing outstanding: act=%0d seq=%h", $time,
                 got.act, got.seq);
        return;
      end
      want = awaited.pop_front();
      if (want != got) begin
        errors++;
        $display("%0t: expected act=%0d seq=%h ref=%h len=%0d tmr=%0d tmo=%h last=%b",
                 $time, want.act, want.seq, want.pref, want.plen, want.tcmd, want.tmo,
                 want.fin);
        $display("%0t: actual   act=%0d seq=%h ref=%h len=%0d tmr=%0d tmo=%h last=%b",
                 $time, got.act, got.seq, got.pref, got.plen, got.tcmd, got.tmo, got.fin);
      end
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_ready_o;
  logic [gbn_pkg::OP_W-1:0]       op_i = '0;
  logic [gbn_pkg::SEQ_W-1:0]      seq_num_i = '0;
  logic                           checksum_ok_i = 1'b0;
  logic [gbn_pkg::REF_W-1:0]      payload_ref_i = '0;
  logic [gbn_pkg::LEN_W-1:0]      payload_len_i = '0;
  logic [gbn_pkg::TMO_W-1:0]      rtt_sample_ns_i = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic [gbn_pkg::ACT_W-1:0]      action_o;
  logic [gbn_pkg::SEQ_W-1:0]      out_seq_o;
  logic [gbn_pkg::REF_W-1:0]      out_ref_o;
  logic [gbn_pkg::LEN_W-1:0]      out_len_o;
  logic [gbn_pkg::TCMD_W-1:0]     timer_cmd_o;
  logic [gbn_pkg::TMO_W-1:0]      timeout_ns_o;
  logic                           last_o;
  logic                           cfg_we_i = 1'b0;
  logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  gbn_expect_book book = new();
  int unsigned    send_idle_pct = 0;
  int unsigned    stall_pct = 0;
  int unsigned    holds_asked = 0;
  int unsigned    holds_served = 0;

  go_back_n_window_engine dut (.*);

  always #4 clk_i = ~clk_i;

  initial begin
    #4_000_000;
    $display("go_back_n_window_engine_tb NOT OK");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off whenever the stimulus asks for one.
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (holds_asked != holds_served) begin
        holds_served++;
        for (int unsigned k = 0; k < 300; k++) begin
          out_ready_i <= 1'b0;
          @(posedge clk_i);
        end
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : watch_results
    gbn_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{act: gbn_pkg::action_e'(action_o), seq: out_seq_o, pref: out_ref_o,
              plen: out_len_o, tcmd: gbn_pkg::timer_e'(timer_cmd_o), tmo: timeout_ns_o,
              fin: last_o};
      book.check_result(got);
    end
  end

  function automatic gbn_event_t mk(gbn_pkg::op_e op, logic [gbn_pkg::SEQ_W-1:0] seq,
                                    logic ck, logic [gbn_pkg::REF_W-1:0] pref,
                                    logic [gbn_pkg::LEN_W-1:0] plen,
                                    logic [gbn_pkg::TMO_W-1:0] sample);
    gbn_event_t ev;
    ev = '{op: op, seq: seq, ck: ck, pref: pref, plen: plen, sample: sample};
    return ev;
  endfunction

  // Mostly well-formed traffic aimed at the current window; the rest is noise.
  function automatic gbn_event_t random_event();
    gbn_event_t                ev;
    int unsigned               pick;
    logic [gbn_pkg::SEQ_W-1:0] outstanding;
    pick        = $urandom_range(99);
    outstanding = book.next_sq - book.base;
    ev = mk(gbn_pkg::OP_SEND, $urandom(), 1'b1, gbn_pkg::REF_W'($urandom()),
            gbn_pkg::LEN_W'($urandom_range(1024)), $urandom_range(2_000_000));
    if ($urandom_range(19) == 0) ev.plen = gbn_pkg::LEN_W'($urandom_range(2047, 1025));
    if ($urandom_range(9) == 0) ev.sample = $urandom();
    if (pick < 35) begin
      ev.op = gbn_pkg::OP_SEND;
    end else if (pick < 60) begin
      ev.op = gbn_pkg::OP_ACK;
      if (outstanding != 0 && $urandom_range(99) < 85) begin
        if ($urandom_range(1)) ev.seq = book.next_sq - 1;
        else ev.seq = book.base + $urandom_range(outstanding - 1);
      end else if ($urandom_range(1)) begin
        ev.seq = book.base - 1 - $urandom_range(3);
      end
    end else if (pick < 85) begin
      ev.op = gbn_pkg::OP_DATA;
      ev.ck = ($urandom_range(9) != 0);
      if ($urandom_range(99) < 80) ev.seq = book.exp_sq;
      else if ($urandom_range(1)) ev.seq = book.exp_sq + $urandom_range(4) - 2;
    end else begin
      ev.op = gbn_pkg::OP_TIMEOUT;
    end
    return ev;
  endfunction

  task automatic offer_event(gbn_event_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    op_i            <= ev.op;
    seq_num_i       <= ev.seq;
    checksum_ok_i   <= ev.ck;
    payload_ref_i   <= ev.pref;
    payload_len_i   <= ev.plen;
    rtt_sample_ns_i <= ev.sample;
    do @(posedge clk_i); while (!in_ready_o);
    book.note_event(ev);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (book.awaited.size() != 0) @(posedge clk_i);
  endtask

  // Wait until every awaited result is out and the sequencer is idle before touching registers.
  task automatic settle();
    drain();
    while (!in_ready_o) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(gbn_pkg::cfg_idx_e idx, logic [gbn_pkg::CFG_DATA_W-1:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    book.set_reg(idx, d);
  endtask

  task automatic program_regs(logic [gbn_pkg::SHIFT_W-1:0] a, logic [gbn_pkg::SHIFT_W-1:0] b,
                              logic en, logic [gbn_pkg::TMO_W-1:0] tmo);
    write_reg(gbn_pkg::CFG_ALPHA, {29'b0, a});
    write_reg(gbn_pkg::CFG_BETA, {29'b0, b});
    write_reg(gbn_pkg::CFG_ADAPT, {31'b0, en});
    write_reg(gbn_pkg::CFG_INIT_TMO, tmo);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(int unsigned n, int unsigned s_idle, int unsigned r_stall,
                            bit with_hold);
    send_idle_pct = s_idle;
    stall_pct     = r_stall;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n / 3) drain();
      if (with_hold && i == n / 2) holds_asked++;
      offer_event(random_event());
    end
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    program_regs(gbn_pkg::ALPHA_RST, gbn_pkg::BETA_RST, 1'b1, gbn_pkg::INIT_TMO_RST);

    // receiver side while the sender is idle, then out-of-order and bad data, a timeout and an oversized send
    offer_event(mk(gbn_pkg::OP_DATA, 32'd1, 1'b1, 16'hFFFF, 11'd1024, 32'd0));
    offer_event(mk(gbn_pkg::OP_DATA, 32'd5, 1'b1, 16'h1234, 11'd10, 32'd0));
    offer_event(mk(gbn_pkg::OP_DATA, 32'd2, 1'b0, 16'h0001, 11'd10, 32'd0));
    offer_event(mk(gbn_pkg::OP_DATA, 32'd2, 1'b1, 16'h0001, 11'd2047, 32'd0));
    offer_event(mk(gbn_pkg::OP_TIMEOUT, 32'd0, 1'b0, 16'h0, 11'd0, 32'd0));
    offer_event(mk(gbn_pkg::OP_SEND, 32'd0, 1'b1, 16'hABCD, 11'd2047, 32'd0));
    // fill the window, then overflow it
    offer_event(mk(gbn_pkg::OP_SEND, 32'hFFFF_FFFF, 1'b1, 16'h0000, 11'd0, 32'd0));
    offer_event(mk(gbn_pkg::OP_SEND, 32'd0, 1'b0, 16'hFFFF, 11'd1024, 32'hFFFF_FFFF));
    for (int unsigned i = 0; i < 6; i++)
      offer_event(mk(gbn_pkg::OP_SEND, $urandom(), 1'b1, gbn_pkg::REF_W'($urandom()),
                     gbn_pkg::LEN_W'($urandom_range(1024)), 32'd0));
    offer_event(mk(gbn_pkg::OP_SEND, 32'd0, 1'b1, 16'h5555, 11'd100, 32'd0));
    // in-order data while busy only repeats the last ack
    offer_event(mk(gbn_pkg::OP_DATA, 32'd2, 1'b1, 16'h0002, 11'd20, 32'd0));
    offer_event(mk(gbn_pkg::OP_ACK, 32'd0, 1'b1, 16'h0, 11'd0, 32'd500));
    offer_event(mk(gbn_pkg::OP_ACK, 32'hFFFF_FFFF, 1'b1, 16'h0, 11'd0, 32'd500));
    offer_event(mk(gbn_pkg::OP_ACK, 32'd3, 1'b1, 16'h0, 11'd0, 32'd0));
    offer_event(mk(gbn_pkg::OP_TIMEOUT, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 11'd2047,
                   32'hFFFF_FFFF));
    offer_event(mk(gbn_pkg::OP_ACK, 32'd8, 1'b1, 16'h0, 11'd0, 32'hFFFF_FFFF));
    offer_event(mk(gbn_pkg::OP_DATA, 32'd2, 1'b1, 16'h00FF, 11'd512, 32'd0));
    offer_event(mk(gbn_pkg::OP_TIMEOUT, 32'd0, 1'b0, 16'h0, 11'd0, 32'd0));
    offer_event(mk(gbn_pkg::OP_ACK, 32'd8, 1'b1, 16'h0, 11'd0, 32'd100));
    run_random(56, 0, 0, 1'b0);
    settle();

    program_regs(3'd0, 3'd0, 1'b1, 32'hFFFF_FFFF);
    run_random(56, 74, 0, 1'b0);
    settle();

    program_regs(3'd7, 3'd7, 1'b1, 32'd0);
    run_random(56, 0, 74, 1'b0);
    settle();

    program_regs(3'd1, 3'd5, 1'b0, 32'd12345);
    run_random(56, 10, 10, 1'b1);
    settle();

    program_regs(gbn_pkg::SHIFT_W'($urandom_range(7)), gbn_pkg::SHIFT_W'($urandom_range(7)),
                 1'b1, $urandom_range(3_000_000));
    run_random(56, 0, 0, 1'b0);
    drain();
    repeat (20) @(posedge clk_i);

    if (book.errors == 0 && book.awaited.size() == 0)
      $display("go_back_n_window_engine_tb OK");
    else
      $display("go_back_n_window_engine_tb NOT OK");
    $finish;
  end

endmodule
